// File: sv/hcbd_pkg.sv
`timescale 1ns / 1ps
package hcbd_pkg;

  localparam int DEF_MAX_HEX_DIGITS = 8;
  localparam int DEF_SIZE_BITS      = 32;
  localparam int TOTAL_BITS         = 32;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_HEX     = 3'd1,
    PH_HEX_LF  = 3'd2,
    PH_PART    = 3'd3,
    PH_PART_CR = 3'd4,
    PH_PART_LF = 3'd5,
    PH_LAST_CR = 3'd6,
    PH_LAST_LF = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_FINAL   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  // parser control state handed between the state register and the step logic
  typedef struct packed {
    phase_t     phase;
    logic [3:0] digit_cnt;
  } ctl_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: sv/hcbd_in_if.sv
`timescale 1ns / 1ps
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: sv/hcbd_out_if.sv
`timescale 1ns / 1ps
interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  byte_kind;
  logic [31:0] total_bytes;

  modport source (output valid, output out_byte, output byte_kind, output total_bytes,
                  input ready);
  modport sink (input valid, input out_byte, input byte_kind, input total_bytes,
                output ready);
endinterface

// File: sv/hcbd_step.sv
`timescale 1ns / 1ps
module hcbd_step #(
  parameter int MAX_HEX_DIGITS = hcbd_pkg::DEF_MAX_HEX_DIGITS,
  parameter int SIZE_BITS      = hcbd_pkg::DEF_SIZE_BITS
) (
  input  logic [7:0]                        data_byte,
  input  hcbd_pkg::ctl_t                    ctl,
  input  logic [SIZE_BITS-1:0]              size_acc,
  input  logic [SIZE_BITS-1:0]              chunk_rem,
  input  logic [hcbd_pkg::TOTAL_BITS-1:0]   total,
  output hcbd_pkg::ctl_t                    ctl_nxt,
  output logic [SIZE_BITS-1:0]              size_acc_nxt,
  output logic [SIZE_BITS-1:0]              chunk_rem_nxt,
  output logic [hcbd_pkg::TOTAL_BITS-1:0]   total_nxt,
  output hcbd_pkg::kind_t                   kind
);

  localparam logic [SIZE_BITS-1:0] SIZE_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

  hcbd_pkg::hex_t       hex;
  logic                 digit_ok;
  logic [SIZE_BITS-1:0] size_shifted;
  logic                 err;

  assign hex          = hcbd_pkg::hex_decode(data_byte);
  // room for one more digit: count below limit and top nibble still clear
  assign digit_ok     = (ctl.digit_cnt < 4'(MAX_HEX_DIGITS)) &&
                        (size_acc[SIZE_BITS-1 -: 4] == 4'd0);
  assign size_shifted = {size_acc[SIZE_BITS-5:0], hex.value};

  assign total_nxt = (total == hcbd_pkg::TOTAL_MAX) ? total
                                                     : total + {{(hcbd_pkg::TOTAL_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    ctl_nxt       = ctl;
    size_acc_nxt  = size_acc;
    chunk_rem_nxt = chunk_rem;
    kind          = hcbd_pkg::KIND_FRAME;
    err           = 1'b0;

    case (ctl.phase)
      hcbd_pkg::PH_START: begin
        if (hex.is_hex && digit_ok) begin
          size_acc_nxt      = size_shifted;
          ctl_nxt.digit_cnt = ctl.digit_cnt + 4'd1;
          ctl_nxt.phase     = hcbd_pkg::PH_HEX;
        end else begin
          err = 1'b1;
        end
      end
      hcbd_pkg::PH_HEX: begin
        if (hex.is_hex) begin
          if (digit_ok) begin
            size_acc_nxt      = size_shifted;
            ctl_nxt.digit_cnt = ctl.digit_cnt + 4'd1;
          end else begin
            err = 1'b1;
          end
        end else if (data_byte == hcbd_pkg::CH_CR) begin
          ctl_nxt.phase = hcbd_pkg::PH_HEX_LF;
        end else if (data_byte != hcbd_pkg::CH_X_LO && data_byte != hcbd_pkg::CH_X_UP) begin
          err = 1'b1;
        end
      end
      hcbd_pkg::PH_HEX_LF: begin
        if (data_byte != hcbd_pkg::CH_LF) begin
          err = 1'b1;
        end else begin
          if (size_acc == '0) begin
            ctl_nxt.phase = hcbd_pkg::PH_LAST_CR;
          end else begin
            chunk_rem_nxt = size_acc;
            ctl_nxt.phase = hcbd_pkg::PH_PART;
          end
          size_acc_nxt      = '0;
          ctl_nxt.digit_cnt = 4'd0;
        end
      end
      hcbd_pkg::PH_PART: begin
        kind = hcbd_pkg::KIND_PAYLOAD;
        if (chunk_rem <= SIZE_ONE) begin
          chunk_rem_nxt = '0;
          ctl_nxt.phase = hcbd_pkg::PH_PART_CR;
        end else begin
          chunk_rem_nxt = chunk_rem - SIZE_ONE;
        end
      end
      hcbd_pkg::PH_PART_CR: begin
        if (data_byte == hcbd_pkg::CH_CR) ctl_nxt.phase = hcbd_pkg::PH_PART_LF;
        else err = 1'b1;
      end
      hcbd_pkg::PH_PART_LF: begin
        if (data_byte == hcbd_pkg::CH_LF) ctl_nxt.phase = hcbd_pkg::PH_START;
        else err = 1'b1;
      end
      hcbd_pkg::PH_LAST_CR: begin
        if (data_byte == hcbd_pkg::CH_CR) ctl_nxt.phase = hcbd_pkg::PH_LAST_LF;
        else err = 1'b1;
      end
      hcbd_pkg::PH_LAST_LF: begin
        if (data_byte == hcbd_pkg::CH_LF) begin
          kind              = hcbd_pkg::KIND_FINAL;
          ctl_nxt.phase     = hcbd_pkg::PH_START;
          ctl_nxt.digit_cnt = 4'd0;
          size_acc_nxt      = '0;
          chunk_rem_nxt     = '0;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase

    if (err) begin
      kind              = hcbd_pkg::KIND_ERROR;
      ctl_nxt.phase     = hcbd_pkg::PH_START;
      ctl_nxt.digit_cnt = 4'd0;
      size_acc_nxt      = '0;
      chunk_rem_nxt     = '0;
    end
  end

endmodule

// File: sv/http_chunked_body_decoder_core.sv
`timescale 1ns / 1ps
// Chunked body decoder: takes one raw byte per word on in_ch and returns exactly one
// result word per byte on out_ch, echoing the byte with its class (framing, payload,
// final LF of the body, or error) and a saturating count of all bytes taken since
// reset. It sustains one byte per clock while out_ch is ready; each byte passes in turn
// through the input register and the result register, and the parser state advances
// when a byte moves from the input register into the result register. Hex size lines
// may hold up to MAX_HEX_DIGITS digits and sizes up to SIZE_BITS bits; anything beyond
// that, or any illegal framing byte, is flagged as an error and the parser restarts
// at the next size line. The byte count is cleared only by reset.
module http_chunked_body_decoder_core #(
  parameter int MAX_HEX_DIGITS = hcbd_pkg::DEF_MAX_HEX_DIGITS,
  parameter int SIZE_BITS      = hcbd_pkg::DEF_SIZE_BITS
) (
  input logic         clk,
  input logic         rst_n,
  hcbd_in_if.sink     in_ch,
  hcbd_out_if.source  out_ch
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // parser state
  hcbd_pkg::ctl_t                  ctl_r;
  hcbd_pkg::ctl_t                  ctl_nxt;
  logic [SIZE_BITS-1:0]            size_acc_r;
  logic [SIZE_BITS-1:0]            size_acc_nxt;
  logic [SIZE_BITS-1:0]            chunk_rem_r;
  logic [SIZE_BITS-1:0]            chunk_rem_nxt;
  logic [hcbd_pkg::TOTAL_BITS-1:0] total_r;
  logic [hcbd_pkg::TOTAL_BITS-1:0] total_nxt;
  hcbd_pkg::kind_t                 kind;

  // result register
  logic                            out_valid_r;
  logic [7:0]                      out_byte_r;
  hcbd_pkg::kind_t                 out_kind_r;
  logic [hcbd_pkg::TOTAL_BITS-1:0] out_total_r;

  logic out_free;
  logic s1_advance;
  logic in_take;

  // result slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_advance = s1_valid_r && out_free;
  // input register accepts when empty or when its byte moves on
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  hcbd_step #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_step (
    .data_byte     (s1_byte_r),
    .ctl           (ctl_r),
    .size_acc      (size_acc_r),
    .chunk_rem     (chunk_rem_r),
    .total         (total_r),
    .ctl_nxt       (ctl_nxt),
    .size_acc_nxt  (size_acc_nxt),
    .chunk_rem_nxt (chunk_rem_nxt),
    .total_nxt     (total_nxt),
    .kind          (kind)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.data_byte;
    end
  end

  // parser state advances once per byte leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '{phase: hcbd_pkg::PH_START, digit_cnt: 4'd0};
      size_acc_r  <= '0;
      chunk_rem_r <= '0;
      total_r     <= '0;
    end else if (s1_advance) begin
      ctl_r       <= ctl_nxt;
      size_acc_r  <= size_acc_nxt;
      chunk_rem_r <= chunk_rem_nxt;
      total_r     <= total_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_byte_r  <= s1_byte_r;
      out_kind_r  <= kind;
      out_total_r <= total_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.byte_kind   = out_kind_r;
  assign out_ch.total_bytes = out_total_r;

endmodule

// File: sv/hcbd_checker.sv
`timescale 1ns / 1ps
module hcbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [1:0]  byte_kind,
  input logic [31:0] total_bytes
);

  logic        in_acc;
  logic        out_acc;
  logic [1:0]  pending_r;
  logic [31:0] last_total_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else begin
      pending_r <= pending_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= 32'd0;
    end else if (out_acc) begin
      last_total_r <= total_bytes;
    end
  end

  // no result without a byte behind it
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 2'd0))
    else $error("result shown with no byte outstanding");

  // full and stalled on the result side: input must be closed
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    ((pending_r == 2'd2) && !out_ready) |-> !in_ready)
    else $error("input open while two bytes in flight and result stalled");

  // byte count steps by one per delivered word, holding at saturation
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> ((total_bytes == last_total_r + 32'd1) ||
                 (total_bytes == 32'hFFFF_FFFF && last_total_r == 32'hFFFF_FFFF)))
    else $error("byte count out of sequence");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) &&
                                   $stable(byte_kind) && $stable(total_bytes)))
    else $error("stalled result word changed");

endmodule

bind http_chunked_body_decoder_core hcbd_checker u_hcbd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .byte_kind   (out_ch.byte_kind),
  .total_bytes (out_ch.total_bytes)
);
